[rtl/csa_pkg.sv]
package csa_pkg;

    // Default sizing of the slot table.
    localparam int NUM_SLOTS_DEF = 64;
    localparam int PTR_BITS_DEF  = 32;

    // Fixed port widths.
    localparam int KIND_W   = 2;
    localparam int CHAN_W   = 6;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int GRANT_W  = 6;
    localparam int FREE_W   = 7;

    typedef enum logic [KIND_W-1:0] {
        KIND_FETCH        = 2'd0,
        KIND_READ         = 2'd1,
        KIND_RELEASE      = 2'd2,
        KIND_RELEASE_WAKE = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK   = 2'd0,
        STATUS_FULL = 2'd1,
        STATUS_IDLE = 2'd2
    } t_status;

    // Result of one operation as decided by the bitmap, without the pointer words.
    typedef struct packed {
        t_status              status;
        logic [GRANT_W-1:0]   granted;
        logic                 wake_channel;
        logic                 wake_waiters;
        logic [FREE_W-1:0]    free_left;
        logic                 rd_ok;
    } t_result;

endpackage

[rtl/csa_bitmap.sv]
module csa_bitmap #(
    parameter int NUM_SLOTS = csa_pkg::NUM_SLOTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_take,
    input  logic [csa_pkg::KIND_W-1:0]        i_kind,
    input  logic [csa_pkg::CHAN_W-1:0]        i_channel,
    output logic                              o_wr_en,
    output logic [$clog2(NUM_SLOTS)-1:0]      o_wr_idx,
    output logic                              o_rd_en,
    output logic [$clog2(NUM_SLOTS)-1:0]      o_rd_idx,
    output csa_pkg::t_result                  o_result
);

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);

    logic [NUM_SLOTS-1:0] r_busy;
    logic [NUM_SLOTS-1:0] n_busy;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;

    logic                 found;
    logic [IDX_W-1:0]     free_idx;
    logic [IDX_W-1:0]     chan_idx;
    logic                 chan_ok;
    logic                 chan_busy;

    // Lowest free slot: scan downward so the lowest index wins.
    always_comb begin
        found    = 1'b0;
        free_idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!r_busy[i]) begin
                found    = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    assign chan_ok   = int'(i_channel) < NUM_SLOTS;
    assign chan_idx  = IDX_W'(i_channel);
    assign chan_busy = chan_ok && r_busy[chan_idx];

    always_comb begin
        n_busy   = r_busy;
        n_count  = r_count;
        o_wr_en  = 1'b0;
        o_wr_idx = free_idx;
        o_rd_en  = 1'b0;
        o_rd_idx = chan_idx;
        o_result = '0;
        o_result.status = csa_pkg::STATUS_OK;
        unique case (csa_pkg::t_kind'(i_kind))
            csa_pkg::KIND_FETCH: begin
                if (!found) begin
                    o_result.status = csa_pkg::STATUS_FULL;
                end else begin
                    o_wr_en          = i_take;
                    n_busy[free_idx] = 1'b1;
                    n_count          = r_count - CNT_W'(1);
                    o_result.granted = csa_pkg::GRANT_W'(free_idx);
                end
            end
            csa_pkg::KIND_READ: begin
                if (!chan_ok) begin
                    o_result.status = csa_pkg::STATUS_IDLE;
                end else begin
                    o_rd_en        = i_take;
                    o_result.rd_ok = 1'b1;
                end
            end
            csa_pkg::KIND_RELEASE, csa_pkg::KIND_RELEASE_WAKE: begin
                if (!chan_busy) begin
                    o_result.status = csa_pkg::STATUS_IDLE;
                end else begin
                    n_busy[chan_idx]      = 1'b0;
                    n_count               = r_count + CNT_W'(1);
                    o_result.wake_channel = (i_kind == csa_pkg::KIND_RELEASE_WAKE);
                    o_result.wake_waiters = (r_count == '0);
                end
            end
        endcase
        o_result.free_left = csa_pkg::FREE_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= '0;
            r_count <= CNT_W'(NUM_SLOTS);
        end else if (i_take) begin
            r_busy  <= n_busy;
            r_count <= n_count;
        end
    end

endmodule

[rtl/csa_store.sv]
module csa_store #(
    parameter int NUM_SLOTS = csa_pkg::NUM_SLOTS_DEF,
    parameter int PTR_BITS  = csa_pkg::PTR_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [$clog2(NUM_SLOTS)-1:0]  i_wr_idx,
    input  logic [csa_pkg::WORD_W-1:0]    i_wr_first,
    input  logic [csa_pkg::WORD_W-1:0]    i_wr_second,
    input  logic                          i_rd_en,
    input  logic [$clog2(NUM_SLOTS)-1:0]  i_rd_idx,
    output logic [csa_pkg::WORD_W-1:0]    o_rd_first,
    output logic [csa_pkg::WORD_W-1:0]    o_rd_second
);

    logic [PTR_BITS-1:0] mem_first  [NUM_SLOTS];
    logic [PTR_BITS-1:0] mem_second [NUM_SLOTS];
    logic [PTR_BITS-1:0] r_rd_first;
    logic [PTR_BITS-1:0] r_rd_second;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_first[i_wr_idx]  <= PTR_BITS'(i_wr_first);
            mem_second[i_wr_idx] <= PTR_BITS'(i_wr_second);
        end
    end

    // Read data holds until the next read, so it doubles as output payload.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_first  <= mem_first[i_rd_idx];
            r_rd_second <= mem_second[i_rd_idx];
        end
    end

    assign o_rd_first  = csa_pkg::WORD_W'(r_rd_first);
    assign o_rd_second = csa_pkg::WORD_W'(r_rd_second);

endmodule

[rtl/channel_slot_allocator.sv]
// Channel slot allocator.
// The input channel (i_in_valid / o_in_ready) carries one request word: kind,
// channel and two pointer words. A fetch claims the lowest free slot and stores
// the pointers there, a read returns a slot's pointers, and a release (with or
// without wakeup) frees a busy slot. The output channel (o_out_valid /
// i_out_ready) returns exactly one result word per request.
// The result is registered, valid in the cycle after its request is accepted.
// Throughput is one request per cycle while the receiver is ready; the priority
// encoder over the busy bitmap and one pointer memory port per table set it.
// When the receiver stalls, the result is held in the output register and the
// memory read register, and o_in_ready drops until the result is taken; a
// request is accepted in the same cycle that the held result leaves.
// Reset clears every busy mark and sets the free count to the table size at
// once; there is no clearing pass. The pointer memories are not reset, and a
// slot's pointers are meaningful only after a fetch has written them.
module channel_slot_allocator #(
    parameter int NUM_SLOTS = csa_pkg::NUM_SLOTS_DEF,
    parameter int PTR_BITS  = csa_pkg::PTR_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [csa_pkg::KIND_W-1:0]    i_kind,
    input  logic [csa_pkg::CHAN_W-1:0]    i_channel,
    input  logic [csa_pkg::WORD_W-1:0]    i_ptr_first,
    input  logic [csa_pkg::WORD_W-1:0]    i_ptr_second,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [csa_pkg::STATUS_W-1:0]  o_status,
    output logic [csa_pkg::GRANT_W-1:0]   o_granted,
    output logic [csa_pkg::WORD_W-1:0]    o_read_first,
    output logic [csa_pkg::WORD_W-1:0]    o_read_second,
    output logic                          o_wake_channel,
    output logic                          o_wake_waiters,
    output logic [csa_pkg::FREE_W-1:0]    o_free_left
);

    localparam int IDX_W = $clog2(NUM_SLOTS);

    logic                   take;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_idx;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_idx;
    csa_pkg::t_result       result;
    csa_pkg::t_result       r_result;
    logic                   r_valid;
    logic [csa_pkg::WORD_W-1:0] rd_first;
    logic [csa_pkg::WORD_W-1:0] rd_second;

    assign o_in_ready = !r_valid || i_out_ready;
    assign take       = i_in_valid && o_in_ready;

    csa_bitmap #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_bitmap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_kind    (i_kind),
        .i_channel (i_channel),
        .o_wr_en   (wr_en),
        .o_wr_idx  (wr_idx),
        .o_rd_en   (rd_en),
        .o_rd_idx  (rd_idx),
        .o_result  (result)
    );

    csa_store #(
        .NUM_SLOTS (NUM_SLOTS),
        .PTR_BITS  (PTR_BITS)
    ) u_store (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_idx    (wr_idx),
        .i_wr_first  (i_ptr_first),
        .i_wr_second (i_ptr_second),
        .i_rd_en     (rd_en),
        .i_rd_idx    (rd_idx),
        .o_rd_first  (rd_first),
        .o_rd_second (rd_second)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_result <= result;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_status       = r_result.status;
    assign o_granted      = r_result.granted;
    assign o_wake_channel = r_result.wake_channel;
    assign o_wake_waiters = r_result.wake_waiters;
    assign o_free_left    = r_result.free_left;
    assign o_read_first   = r_result.rd_ok ? rd_first : '0;
    assign o_read_second  = r_result.rd_ok ? rd_second : '0;

endmodule

[rtl/csa_checker.sv]
module csa_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          o_in_ready,
    input  logic                          o_out_valid,
    input  logic                          i_out_ready,
    input  logic [csa_pkg::STATUS_W-1:0]  o_status,
    input  logic [csa_pkg::GRANT_W-1:0]   o_granted,
    input  logic                          o_wake_channel,
    input  logic                          o_wake_waiters,
    input  logic [csa_pkg::FREE_W-1:0]    o_free_left
);

    // An accepted request always has its result word waiting in the next cycle.
    a_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("accepted request produced no result word");

    // A stalled result word stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_granted) && $stable(o_free_left))
        else $error("output word changed while stalled");

    // A full table means no slot is left.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == csa_pkg::STATUS_FULL |-> o_free_left == '0
            && o_granted == '0)
        else $error("full status with free slots reported");

    // Only a successful fetch grants a nonzero slot, and it wakes nobody.
    a_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_granted != '0 |-> o_status == csa_pkg::STATUS_OK
            && !o_wake_channel && !o_wake_waiters)
        else $error("grant outside a successful fetch");

    // Waking the waiters means the count just came back to one.
    a_wake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_wake_waiters |-> o_status == csa_pkg::STATUS_OK
            && o_free_left == csa_pkg::FREE_W'(1))
        else $error("waiter wakeup without a restore to one free slot");

endmodule

bind channel_slot_allocator csa_checker u_csa_checker (.*);
